@@ rtl/core/sfcs_pkg.sv @@
`timescale 1ns / 1ps
package sfcs_pkg;

    localparam int ADDR_BYTES  = 3;
    localparam int LENGTH_BITS = 16;
    localparam int CNT_W       = LENGTH_BITS + 2;
    localparam int MAX_RES     = 4;
    localparam int RES_CNT_W   = 3;

    typedef enum logic [1:0] {
        MODE_REQ  = 2'd0,
        MODE_DATA = 2'd1,
        MODE_RX   = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        OP_READ   = 4'd0,
        OP_PROG   = 4'd1,
        OP_SERASE = 4'd2,
        OP_CERASE = 4'd3,
        OP_STATUS = 4'd4,
        OP_ID     = 4'd5,
        OP_WREN   = 4'd6,
        OP_RESET  = 4'd7,
        OP_QUAD   = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ACT_SEL   = 3'd0,
        ACT_SEND  = 3'd1,
        ACT_DESEL = 3'd2,
        ACT_DATA  = 3'd3,
        ACT_DONE  = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_LEN   = 2'd1,
        ERR_ALIGN = 2'd2,
        ERR_WEL   = 2'd3
    } err_t;

    typedef enum logic [10:0] {
        PH_IDLE      = 11'b000_0000_0001,
        PH_OPCODE    = 11'b000_0000_0010,
        PH_WREN      = 11'b000_0000_0100,
        PH_WCHK_CMD  = 11'b000_0000_1000,
        PH_WCHK_DATA = 11'b000_0001_0000,
        PH_ADDR      = 11'b000_0010_0000,
        PH_READ      = 11'b000_0100_0000,
        PH_WAITDATA  = 11'b000_1000_0000,
        PH_WBYTE     = 11'b001_0000_0000,
        PH_POLL_CMD  = 11'b010_0000_0000,
        PH_POLL_DATA = 11'b100_0000_0000
    } phase_t;

    typedef enum logic {
        CFG_ALIGN_MASK = 1'b0,
        CFG_PAGE_LIMIT = 1'b1
    } cfg_idx_t;

    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_PROG   = 8'h02;
    localparam logic [7:0] CMD_SERASE = 8'h20;
    localparam logic [7:0] CMD_CERASE = 8'hC7;
    localparam logic [7:0] CMD_RDSR1  = 8'h05;
    localparam logic [7:0] CMD_RDSR2  = 8'h35;
    localparam logic [7:0] CMD_RDSR3  = 8'h15;
    localparam logic [7:0] CMD_WREN   = 8'h06;
    localparam logic [7:0] CMD_RSTEN  = 8'h66;
    localparam logic [7:0] CMD_RST    = 8'h99;
    localparam logic [7:0] CMD_ID     = 8'h90;
    localparam logic [7:0] CMD_QUAD   = 8'hEB;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  operation;
        logic [23:0] address;
        logic [15:0] length;
        logic        pack_words;
        logic [2:0]  status_index;
        logic [31:0] program_word;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tx_byte;
        logic [31:0] data_out;
        logic [1:0]  error_code;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        out_item_t [MAX_RES-1:0] res;
    } res_batch_t;

    typedef struct packed {
        logic [7:0] align_mask;
        logic [6:0] page_word_limit;
    } cfg_t;

    function automatic out_item_t mk(input act_t a, input logic [7:0] tx,
                                     input logic [31:0] d, input err_t e);
        out_item_t r;
        r.action     = a;
        r.tx_byte    = tx;
        r.data_out   = d;
        r.error_code = e;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/core/spi_nor_flash_command_sequencer_unit.sv @@
`timescale 1ns / 1ps
// channel  | ports                               | dir
// request  | s_valid s_ready s_data (in_item_t)  | in
// result   | m_valid m_ready m_data (out_item_t) | out
// config   | cfg_we cfg_index cfg_wdata          | in
// An item is decoded in the cycle it is accepted; its 0..3 results are
// registered and leave the result queue one per cycle while m_ready is high.
// s_ready is high when the queue is empty or its last result goes out this
// cycle, so with m_ready held high, single-result items flow one per cycle.
// Reset (aresetn low, synchronous) idles the sequencer and empties the queue.
module spi_nor_flash_command_sequencer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sfcs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sfcs_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata
);
    sfcs_pkg::cfg_t       cfg_reg;
    sfcs_pkg::res_batch_t batch;
    logic                 empty;
    logic                 acc;

    assign s_ready = empty;
    assign acc     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.align_mask      <= 8'd63;
            cfg_reg.page_word_limit <= 7'd64;
        end else if (cfg_we) begin
            unique case (sfcs_pkg::cfg_idx_t'(cfg_index))
                sfcs_pkg::CFG_ALIGN_MASK: cfg_reg.align_mask <= cfg_wdata;
                sfcs_pkg::CFG_PAGE_LIMIT: cfg_reg.page_word_limit <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    sfcs_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (acc),
        .item       (s_data),
        .cfg        (cfg_reg),
        .batch      (batch)
    );

    sfcs_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (acc),
        .batch   (batch),
        .empty   (empty),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

@@ rtl/core/sfcs_engine.sv @@
`timescale 1ns / 1ps
module sfcs_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  sfcs_pkg::in_item_t  item,
    input  sfcs_pkg::cfg_t      cfg,
    output sfcs_pkg::res_batch_t batch
);
    typedef logic [sfcs_pkg::CNT_W-1:0] cnt_t;

    sfcs_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  op_reg, op_next;
    logic [23:0] addr_reg, addr_next;
    cnt_t        cnt_reg, cnt_next;
    logic [1:0]  biw_reg, biw_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] ow_reg, ow_next;
    logic        pack_reg, pack_next;
    logic [1:0]  rr_reg, rr_next;

    sfcs_pkg::out_item_t [sfcs_pkg::MAX_RES-1:0] r;
    logic [sfcs_pkg::RES_CNT_W-1:0] n;
    logic [1:0] alen_m1;
    logic [7:0] abyte;
    logic [7:0] wcmd;
    logic [7:0] sr_cmd;
    logic [31:0] asm_new;
    cnt_t        cnt_dec;

    always_comb begin
        alen_m1 = (op_reg == sfcs_pkg::OP_ID) ? 2'd2 : 2'(sfcs_pkg::ADDR_BYTES - 1);
    end

    always_comb begin
        phase_next = phase_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        biw_next   = biw_reg;
        asm_next   = asm_reg;
        ow_next    = ow_reg;
        pack_next  = pack_reg;
        rr_next    = rr_reg;
        r = '0;
        n = '0;
        abyte = '0;
        wcmd = '0;
        sr_cmd = '0;
        asm_new = '0;
        cnt_dec = cnt_reg - cnt_t'(1);
        if (item_valid) begin
            case (sfcs_pkg::mode_t'(item.mode))
                sfcs_pkg::MODE_REQ: begin
                    if (phase_reg == sfcs_pkg::PH_IDLE) begin
                        op_next   = item.operation;
                        addr_next = item.address;
                        pack_next = 1'b0;
                        biw_next  = '0;
                        asm_next  = '0;
                        rr_next   = '0;
                        cnt_next  = '0;
                        r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_SEL, 8'd0, 32'd0, sfcs_pkg::ERR_OK);
                        n = 3'd2;
                        phase_next = sfcs_pkg::PH_OPCODE;
                        unique case (item.operation)
                            sfcs_pkg::OP_READ: begin
                                pack_next = item.pack_words;
                                cnt_next = item.pack_words ? {item.length, 2'b00}
                                                           : cnt_t'(item.length);
                                r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::CMD_READ,
                                                    32'd0, sfcs_pkg::ERR_OK);
                            end
                            sfcs_pkg::OP_PROG: begin
                                if (item.length > 16'(cfg.page_word_limit)) begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_LEN);
                                    n = 3'd1;
                                    phase_next = sfcs_pkg::PH_IDLE;
                                end else if ((item.address[7:0] & cfg.align_mask) != 8'd0)
                                begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_ALIGN);
                                    n = 3'd1;
                                    phase_next = sfcs_pkg::PH_IDLE;
                                end else begin
                                    cnt_next = cnt_t'(item.length);
                                    r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::CMD_WREN,
                                                        32'd0, sfcs_pkg::ERR_OK);
                                    phase_next = sfcs_pkg::PH_WREN;
                                end
                            end
                            sfcs_pkg::OP_SERASE, sfcs_pkg::OP_CERASE: begin
                                r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::CMD_WREN,
                                                    32'd0, sfcs_pkg::ERR_OK);
                                phase_next = sfcs_pkg::PH_WREN;
                            end
                            sfcs_pkg::OP_STATUS: begin
                                if (item.status_index < 3'd1 || item.status_index > 3'd3)
                                begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DATA, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    phase_next = sfcs_pkg::PH_IDLE;
                                end else begin
                                    cnt_next = cnt_t'(1);
                                    sr_cmd = (item.status_index == 3'd1) ? sfcs_pkg::CMD_RDSR1 :
                                             (item.status_index == 3'd2) ? sfcs_pkg::CMD_RDSR2 :
                                                                           sfcs_pkg::CMD_RDSR3;
                                    r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sr_cmd, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                end
                            end
                            sfcs_pkg::OP_ID: begin
                                addr_next = '0;
                                cnt_next = cnt_t'(2);
                                r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::CMD_ID,
                                                    32'd0, sfcs_pkg::ERR_OK);
                            end
                            sfcs_pkg::OP_WREN: r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                sfcs_pkg::CMD_WREN, 32'd0, sfcs_pkg::ERR_OK);
                            sfcs_pkg::OP_RESET: r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                sfcs_pkg::CMD_RSTEN, 32'd0, sfcs_pkg::ERR_OK);
                            sfcs_pkg::OP_QUAD: r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                sfcs_pkg::CMD_QUAD, 32'd0, sfcs_pkg::ERR_OK);
                            default: begin
                                r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                    sfcs_pkg::ERR_OK);
                                n = 3'd1;
                                phase_next = sfcs_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
                sfcs_pkg::MODE_DATA: begin
                    if (phase_reg == sfcs_pkg::PH_WAITDATA) begin
                        ow_next = item.program_word;
                        biw_next = '0;
                        r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, item.program_word[31:24],
                                            32'd0, sfcs_pkg::ERR_OK);
                        n = 3'd1;
                        phase_next = sfcs_pkg::PH_WBYTE;
                    end
                end
                sfcs_pkg::MODE_RX: begin
                    unique case (phase_reg)
                        sfcs_pkg::PH_OPCODE: begin
                            case (op_reg)
                                sfcs_pkg::OP_READ, sfcs_pkg::OP_PROG, sfcs_pkg::OP_SERASE,
                                sfcs_pkg::OP_ID: begin
                                    biw_next = '0;
                                    abyte = 8'(addr_reg >> {alen_m1, 3'b000});
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, abyte, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    n = 3'd1;
                                    phase_next = sfcs_pkg::PH_ADDR;
                                end
                                sfcs_pkg::OP_CERASE: begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEL, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    r[2] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::CMD_RDSR1,
                                                        32'd0, sfcs_pkg::ERR_OK);
                                    n = 3'd3;
                                    phase_next = sfcs_pkg::PH_POLL_CMD;
                                end
                                sfcs_pkg::OP_STATUS: begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    n = 3'd1;
                                    phase_next = sfcs_pkg::PH_READ;
                                end
                                sfcs_pkg::OP_RESET: begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    if (rr_reg < 2'd3) begin
                                        rr_next = rr_reg + 2'd1;
                                        r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEL, 8'd0, 32'd0,
                                                            sfcs_pkg::ERR_OK);
                                        r[2] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                            rr_next[0] ? sfcs_pkg::CMD_RST : sfcs_pkg::CMD_RSTEN,
                                            32'd0, sfcs_pkg::ERR_OK);
                                        n = 3'd3;
                                    end else begin
                                        rr_next = '0;
                                        r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                            sfcs_pkg::ERR_OK);
                                        n = 3'd2;
                                        phase_next = sfcs_pkg::PH_IDLE;
                                    end
                                end
                                default: begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    n = 3'd2;
                                    phase_next = sfcs_pkg::PH_IDLE;
                                end
                            endcase
                        end
                        sfcs_pkg::PH_WREN: begin
                            r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                sfcs_pkg::ERR_OK);
                            r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEL, 8'd0, 32'd0, sfcs_pkg::ERR_OK);
                            r[2] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::CMD_RDSR1, 32'd0,
                                                sfcs_pkg::ERR_OK);
                            n = 3'd3;
                            phase_next = sfcs_pkg::PH_WCHK_CMD;
                        end
                        sfcs_pkg::PH_WCHK_CMD, sfcs_pkg::PH_POLL_CMD: begin
                            r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, 8'd0, 32'd0,
                                                sfcs_pkg::ERR_OK);
                            n = 3'd1;
                            phase_next = (phase_reg == sfcs_pkg::PH_WCHK_CMD) ?
                                         sfcs_pkg::PH_WCHK_DATA : sfcs_pkg::PH_POLL_DATA;
                        end
                        sfcs_pkg::PH_WCHK_DATA: begin
                            r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                sfcs_pkg::ERR_OK);
                            if (!item.rx_byte[1]) begin
                                r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                    sfcs_pkg::ERR_WEL);
                                n = 3'd2;
                                phase_next = sfcs_pkg::PH_IDLE;
                            end else begin
                                wcmd = (op_reg == sfcs_pkg::OP_PROG) ? sfcs_pkg::CMD_PROG :
                                       (op_reg == sfcs_pkg::OP_SERASE) ? sfcs_pkg::CMD_SERASE :
                                                                         sfcs_pkg::CMD_CERASE;
                                r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEL, 8'd0, 32'd0,
                                                    sfcs_pkg::ERR_OK);
                                r[2] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, wcmd, 32'd0,
                                                    sfcs_pkg::ERR_OK);
                                n = 3'd3;
                                phase_next = sfcs_pkg::PH_OPCODE;
                            end
                        end
                        sfcs_pkg::PH_ADDR: begin
                            if (biw_reg < alen_m1) begin
                                biw_next = biw_reg + 2'd1;
                                abyte = 8'(addr_reg >> {alen_m1 - biw_next, 3'b000});
                                r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, abyte, 32'd0,
                                                    sfcs_pkg::ERR_OK);
                                n = 3'd1;
                            end else begin
                                biw_next = '0;
                                if ((op_reg == sfcs_pkg::OP_READ && cnt_reg != '0) ||
                                    op_reg == sfcs_pkg::OP_ID) begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    n = 3'd1;
                                    phase_next = sfcs_pkg::PH_READ;
                                end else if (op_reg == sfcs_pkg::OP_READ) begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    n = 3'd2;
                                    phase_next = sfcs_pkg::PH_IDLE;
                                end else if (op_reg == sfcs_pkg::OP_PROG && cnt_reg != '0)
                                begin
                                    phase_next = sfcs_pkg::PH_WAITDATA;
                                end else begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEL, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    r[2] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                        sfcs_pkg::CMD_RDSR1, 32'd0, sfcs_pkg::ERR_OK);
                                    n = 3'd3;
                                    phase_next = sfcs_pkg::PH_POLL_CMD;
                                end
                            end
                        end
                        sfcs_pkg::PH_READ: begin
                            cnt_next = cnt_dec;
                            if (pack_reg) begin
                                asm_new = asm_reg |
                                          ({item.rx_byte, 24'd0} >> {biw_reg, 3'b000});
                                if (biw_reg == 2'd3) begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DATA, 8'd0, asm_new,
                                                        sfcs_pkg::ERR_OK);
                                    n = 3'd1;
                                    asm_next = '0;
                                    biw_next = '0;
                                end else begin
                                    asm_next = asm_new;
                                    biw_next = biw_reg + 2'd1;
                                end
                            end else begin
                                r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DATA, 8'd0,
                                                    {24'd0, item.rx_byte}, sfcs_pkg::ERR_OK);
                                n = 3'd1;
                            end
                            if (cnt_dec == '0) begin
                                r[n[1:0]] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                         sfcs_pkg::ERR_OK);
                                r[2'(n + 3'd1)] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                         sfcs_pkg::ERR_OK);
                                n = n + 3'd2;
                                phase_next = sfcs_pkg::PH_IDLE;
                            end else begin
                                r[n[1:0]] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, 8'd0, 32'd0,
                                                         sfcs_pkg::ERR_OK);
                                n = n + 3'd1;
                            end
                        end
                        sfcs_pkg::PH_WBYTE: begin
                            if (biw_reg == 2'd3) begin
                                biw_next = '0;
                                cnt_next = cnt_dec;
                                if (cnt_dec == '0) begin
                                    r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEL, 8'd0, 32'd0,
                                                        sfcs_pkg::ERR_OK);
                                    r[2] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND,
                                        sfcs_pkg::CMD_RDSR1, 32'd0, sfcs_pkg::ERR_OK);
                                    n = 3'd3;
                                    phase_next = sfcs_pkg::PH_POLL_CMD;
                                end else begin
                                    phase_next = sfcs_pkg::PH_WAITDATA;
                                end
                            end else begin
                                biw_next = biw_reg + 2'd1;
                                abyte = 8'(ow_reg >> {~biw_next, 3'b000});
                                r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, abyte, 32'd0,
                                                    sfcs_pkg::ERR_OK);
                                n = 3'd1;
                            end
                        end
                        sfcs_pkg::PH_POLL_DATA: begin
                            r[0] = sfcs_pkg::mk(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0,
                                                sfcs_pkg::ERR_OK);
                            if (item.rx_byte[0]) begin
                                r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_SEL, 8'd0, 32'd0,
                                                    sfcs_pkg::ERR_OK);
                                r[2] = sfcs_pkg::mk(sfcs_pkg::ACT_SEND, sfcs_pkg::CMD_RDSR1,
                                                    32'd0, sfcs_pkg::ERR_OK);
                                n = 3'd3;
                                phase_next = sfcs_pkg::PH_POLL_CMD;
                            end else begin
                                r[1] = sfcs_pkg::mk(sfcs_pkg::ACT_DONE, 8'd0, 32'd0,
                                                    sfcs_pkg::ERR_OK);
                                n = 3'd2;
                                phase_next = sfcs_pkg::PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (n != '0) begin
            r[2'(n - 3'd1)].last = 1'b1;
        end
        batch.count = n;
        batch.res   = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sfcs_pkg::PH_IDLE;
            op_reg    <= '0;
            addr_reg  <= '0;
            cnt_reg   <= '0;
            biw_reg   <= '0;
            asm_reg   <= '0;
            pack_reg  <= 1'b0;
            rr_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            biw_reg   <= biw_next;
            asm_reg   <= asm_next;
            pack_reg  <= pack_next;
            rr_reg    <= rr_next;
        end
    end

    always_ff @(posedge aclk) begin
        ow_reg <= ow_next;
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(phase_reg))
        else $error("phase not one-hot");
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        batch.count <= 3'(sfcs_pkg::MAX_RES)) else $error("too many results");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (!item_valid) |-> (batch.count == '0 && phase_next == phase_reg))
        else $error("work without item");
endmodule

@@ rtl/core/sfcs_out_queue.sv @@
`timescale 1ns / 1ps
module sfcs_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  sfcs_pkg::res_batch_t batch,
    output logic                 empty,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sfcs_pkg::out_item_t  m_data
);
    sfcs_pkg::out_item_t [sfcs_pkg::MAX_RES-1:0] buf_reg;
    logic [sfcs_pkg::RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg, rd_next;
    logic       pop;

    assign m_valid = cnt_reg != '0;
    assign m_data  = buf_reg[rd_reg];
    assign pop     = m_valid && m_ready;
    assign empty   = (cnt_reg == '0) || (cnt_reg == 3'd1 && pop);

    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load) begin
            cnt_next = batch.count;
            rd_next  = '0;
        end else if (pop) begin
            cnt_next = cnt_reg - 3'd1;
            rd_next  = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= batch.res;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> empty) else $error("load over pending items");
    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cnt_reg == 3'd1) |-> m_data.last) else $error("last missing");
    a_last_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cnt_reg > 3'd1) |-> !m_data.last) else $error("early last");
endmodule

@@ test/tb_spi_nor_flash_command_sequencer_unit.sv @@
`timescale 1ns / 1ps
module tb_spi_nor_flash_command_sequencer_unit;

    class flash_seq_scoreboard;
        logic [7:0]                 align_mask;
        logic [6:0]                 page_limit;
        sfcs_pkg::phase_t           ph;
        logic [3:0]                 cur_op;
        logic [23:0]                addr;
        logic [sfcs_pkg::CNT_W-1:0] remaining;
        logic [1:0]                 byte_idx;
        logic [31:0]                gathered;
        logic [31:0]                prog_word;
        logic                       pack;
        logic [1:0]                 rst_step;
        sfcs_pkg::out_item_t        batch[$];
        sfcs_pkg::out_item_t        actions_due[$];
        int                         n_results;

        function void clear();
            align_mask = 8'd63;
            page_limit = 7'd64;
            ph = sfcs_pkg::PH_IDLE;
            cur_op = '0;
            addr = '0;
            remaining = '0;
            byte_idx = '0;
            gathered = '0;
            prog_word = '0;
            pack = 1'b0;
            rst_step = '0;
            actions_due.delete();
            n_results = 0;
        endfunction

        function void emit(sfcs_pkg::act_t a, logic [7:0] tx, logic [31:0] d,
                           sfcs_pkg::err_t e);
            sfcs_pkg::out_item_t r;
            r.action = a;
            r.tx_byte = tx;
            r.data_out = d;
            r.error_code = e;
            r.last = 1'b0;
            batch.push_back(r);
        endfunction

        function void done(sfcs_pkg::err_t e);
            emit(sfcs_pkg::ACT_DONE, 8'd0, 32'd0, e);
            ph = sfcs_pkg::PH_IDLE;
        endfunction

        function void send(logic [7:0] b);
            emit(sfcs_pkg::ACT_SEND, b, 32'd0, sfcs_pkg::ERR_OK);
        endfunction

        function void poll();
            emit(sfcs_pkg::ACT_SEL, 8'd0, 32'd0, sfcs_pkg::ERR_OK);
            send(sfcs_pkg::CMD_RDSR1);
            ph = sfcs_pkg::PH_POLL_CMD;
        endfunction

        function void desel();
            emit(sfcs_pkg::ACT_DESEL, 8'd0, 32'd0, sfcs_pkg::ERR_OK);
        endfunction

        function void start_cmd(logic [7:0] c, sfcs_pkg::phase_t nxt);
            emit(sfcs_pkg::ACT_SEL, 8'd0, 32'd0, sfcs_pkg::ERR_OK);
            send(c);
            ph = nxt;
        endfunction

        function void request(sfcs_pkg::in_item_t it);
            cur_op = it.operation;
            addr = it.address;
            pack = 1'b0;
            byte_idx = '0;
            gathered = '0;
            rst_step = '0;
            remaining = '0;
            case (it.operation)
                sfcs_pkg::OP_READ: begin
                    pack = it.pack_words;
                    remaining = it.pack_words ? {it.length, 2'b00}
                                              : sfcs_pkg::CNT_W'(it.length);
                    start_cmd(sfcs_pkg::CMD_READ, sfcs_pkg::PH_OPCODE);
                end
                sfcs_pkg::OP_PROG: begin
                    if (it.length > page_limit) done(sfcs_pkg::ERR_LEN);
                    else if ((it.address[7:0] & align_mask) != 0) done(sfcs_pkg::ERR_ALIGN);
                    else begin
                        remaining = sfcs_pkg::CNT_W'(it.length);
                        start_cmd(sfcs_pkg::CMD_WREN, sfcs_pkg::PH_WREN);
                    end
                end
                sfcs_pkg::OP_SERASE, sfcs_pkg::OP_CERASE:
                    start_cmd(sfcs_pkg::CMD_WREN, sfcs_pkg::PH_WREN);
                sfcs_pkg::OP_STATUS: begin
                    if (it.status_index < 1 || it.status_index > 3) begin
                        emit(sfcs_pkg::ACT_DATA, 8'd0, 32'd0, sfcs_pkg::ERR_OK);
                        done(sfcs_pkg::ERR_OK);
                    end else begin
                        remaining = sfcs_pkg::CNT_W'(1);
                        start_cmd(it.status_index == 1 ? sfcs_pkg::CMD_RDSR1 :
                                  it.status_index == 2 ? sfcs_pkg::CMD_RDSR2 :
                                                         sfcs_pkg::CMD_RDSR3,
                                  sfcs_pkg::PH_OPCODE);
                    end
                end
                sfcs_pkg::OP_ID: begin
                    addr = '0;
                    remaining = sfcs_pkg::CNT_W'(2);
                    start_cmd(sfcs_pkg::CMD_ID, sfcs_pkg::PH_OPCODE);
                end
                sfcs_pkg::OP_WREN: start_cmd(sfcs_pkg::CMD_WREN, sfcs_pkg::PH_OPCODE);
                sfcs_pkg::OP_RESET: start_cmd(sfcs_pkg::CMD_RSTEN, sfcs_pkg::PH_OPCODE);
                sfcs_pkg::OP_QUAD: start_cmd(sfcs_pkg::CMD_QUAD, sfcs_pkg::PH_OPCODE);
                default: done(sfcs_pkg::ERR_OK);
            endcase
        endfunction

        function void addr_byte();
            send(8'(addr >> (8 * (sfcs_pkg::ADDR_BYTES - 1 - byte_idx))));
        endfunction

        function void read_byte(logic [7:0] rx);
            if (pack) begin
                gathered = gathered | (32'(rx) << (24 - 8 * byte_idx));
                if (byte_idx == 3) begin
                    emit(sfcs_pkg::ACT_DATA, 8'd0, gathered, sfcs_pkg::ERR_OK);
                    gathered = '0;
                    byte_idx = '0;
                end else byte_idx++;
            end else emit(sfcs_pkg::ACT_DATA, 8'd0, 32'(rx), sfcs_pkg::ERR_OK);
            remaining = remaining - 1'b1;
            if (remaining == 0) begin
                desel();
                done(sfcs_pkg::ERR_OK);
            end else send(8'd0);
        endfunction

        function void echo(logic [7:0] rx);
            case (ph)
                sfcs_pkg::PH_OPCODE: begin
                    case (cur_op)
                        sfcs_pkg::OP_READ, sfcs_pkg::OP_PROG, sfcs_pkg::OP_SERASE,
                        sfcs_pkg::OP_ID: begin
                            byte_idx = '0;
                            addr_byte();
                            ph = sfcs_pkg::PH_ADDR;
                        end
                        sfcs_pkg::OP_CERASE: begin desel(); poll(); end
                        sfcs_pkg::OP_STATUS: begin send(8'd0); ph = sfcs_pkg::PH_READ; end
                        sfcs_pkg::OP_RESET: begin
                            desel();
                            if (rst_step < 3) begin
                                rst_step++;
                                emit(sfcs_pkg::ACT_SEL, 8'd0, 32'd0, sfcs_pkg::ERR_OK);
                                send(rst_step[0] ? sfcs_pkg::CMD_RST : sfcs_pkg::CMD_RSTEN);
                            end else begin
                                rst_step = '0;
                                done(sfcs_pkg::ERR_OK);
                            end
                        end
                        default: begin desel(); done(sfcs_pkg::ERR_OK); end
                    endcase
                end
                sfcs_pkg::PH_WREN: begin
                    desel();
                    start_cmd(sfcs_pkg::CMD_RDSR1, sfcs_pkg::PH_WCHK_CMD);
                end
                sfcs_pkg::PH_WCHK_CMD: begin send(8'd0); ph = sfcs_pkg::PH_WCHK_DATA; end
                sfcs_pkg::PH_WCHK_DATA: begin
                    desel();
                    if (!rx[1]) done(sfcs_pkg::ERR_WEL);
                    else start_cmd(cur_op == sfcs_pkg::OP_PROG ? sfcs_pkg::CMD_PROG :
                                   cur_op == sfcs_pkg::OP_SERASE ? sfcs_pkg::CMD_SERASE :
                                                                   sfcs_pkg::CMD_CERASE,
                                   sfcs_pkg::PH_OPCODE);
                end
                sfcs_pkg::PH_ADDR: begin
                    if (byte_idx + 1 < sfcs_pkg::ADDR_BYTES) begin
                        byte_idx++;
                        addr_byte();
                    end else begin
                        byte_idx = '0;
                        case (cur_op)
                            sfcs_pkg::OP_READ: begin
                                if (remaining == 0) begin desel(); done(sfcs_pkg::ERR_OK); end
                                else begin send(8'd0); ph = sfcs_pkg::PH_READ; end
                            end
                            sfcs_pkg::OP_ID: begin send(8'd0); ph = sfcs_pkg::PH_READ; end
                            sfcs_pkg::OP_PROG: begin
                                if (remaining == 0) begin desel(); poll(); end
                                else ph = sfcs_pkg::PH_WAITDATA;
                            end
                            default: begin desel(); poll(); end
                        endcase
                    end
                end
                sfcs_pkg::PH_READ: read_byte(rx);
                sfcs_pkg::PH_WBYTE: begin
                    if (byte_idx == 3) begin
                        byte_idx = '0;
                        remaining = remaining - 1'b1;
                        if (remaining == 0) begin desel(); poll(); end
                        else ph = sfcs_pkg::PH_WAITDATA;
                    end else begin
                        byte_idx++;
                        send(8'(prog_word >> (24 - 8 * byte_idx)));
                    end
                end
                sfcs_pkg::PH_POLL_CMD: begin send(8'd0); ph = sfcs_pkg::PH_POLL_DATA; end
                sfcs_pkg::PH_POLL_DATA: begin
                    desel();
                    if (rx[0]) poll();
                    else done(sfcs_pkg::ERR_OK);
                end
                default: ;
            endcase
        endfunction

        // returns the number of results the item causes
        function int note_input(sfcs_pkg::in_item_t it);
            batch.delete();
            case (it.mode)
                sfcs_pkg::MODE_REQ: if (ph == sfcs_pkg::PH_IDLE) request(it);
                sfcs_pkg::MODE_DATA: if (ph == sfcs_pkg::PH_WAITDATA) begin
                    prog_word = it.program_word;
                    byte_idx = '0;
                    send(it.program_word[31:24]);
                    ph = sfcs_pkg::PH_WBYTE;
                end
                sfcs_pkg::MODE_RX: echo(it.rx_byte);
                default: ;
            endcase
            if (batch.size() > 0) batch[$].last = 1'b1;
            foreach (batch[i]) actions_due.push_back(batch[i]);
            return batch.size();
        endfunction

        function string check_result(sfcs_pkg::out_item_t got);
            sfcs_pkg::out_item_t want;
            n_results++;
            if (actions_due.size() == 0) return $sformatf("unexpected result %p", got);
            want = actions_due.pop_front();
            if (got !== want) return $sformatf("got %p want %p", got, want);
            return "";
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    sfcs_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    sfcs_pkg::out_item_t m_data;
    logic                cfg_we;
    logic                cfg_index;
    logic [7:0]          cfg_wdata;

    flash_seq_scoreboard sb;
    int  n_errors;
    int  n_sent;
    int  n_requests;
    bit  hold_req;

    spi_nor_flash_command_sequencer_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    task automatic report(string msg);
        n_errors++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        string msg;
        if (aresetn && m_valid && m_ready) begin
            msg = sb.check_result(m_data);
            if (msg != "") report(msg);
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode_sel;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            mode_sel = $urandom_range(0, 3);
            if (hold_req) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_req = 1'b0;
            end
            repeat ($urandom_range(4, 40)) begin
                @(negedge aclk);
                case (mode_sel)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    function automatic sfcs_pkg::in_item_t random_fields();
        sfcs_pkg::in_item_t it;
        logic [95:0]        raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(sfcs_pkg::in_item_t)-1:0];
        return it;
    endfunction

    task automatic push_item(sfcs_pkg::in_item_t it);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (it.mode == sfcs_pkg::MODE_REQ && sb.ph == sfcs_pkg::PH_IDLE) n_requests++;
        if (sb.note_input(it) > 0) n_sent++;
    endtask

    task automatic pause(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_data <= random_fields();
        end
    endtask

    // item that moves the current operation along
    function automatic sfcs_pkg::in_item_t follow_item();
        sfcs_pkg::in_item_t it;
        it = random_fields();
        if (sb.ph == sfcs_pkg::PH_WAITDATA) it.mode = sfcs_pkg::MODE_DATA;
        else it.mode = sfcs_pkg::MODE_RX;
        if (sb.ph == sfcs_pkg::PH_WCHK_DATA) it.rx_byte[1] = ($urandom_range(0, 7) != 0);
        if (sb.ph == sfcs_pkg::PH_POLL_DATA) it.rx_byte[0] = ($urandom_range(0, 2) == 0);
        return it;
    endfunction

    function automatic sfcs_pkg::in_item_t random_request();
        sfcs_pkg::in_item_t it;
        it = random_fields();
        it.mode = sfcs_pkg::MODE_REQ;
        it.operation = $urandom_range(0, 10) == 0 ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
        if (it.operation == sfcs_pkg::OP_READ) it.length = 16'($urandom_range(0, 7));
        if (it.operation == sfcs_pkg::OP_PROG) begin
            if ($urandom_range(0, 3) != 0) begin
                it.length = 16'($urandom_range(0, 5));
                it.address[7:0] = it.address[7:0] & ~sb.align_mask;
            end
        end
        return it;
    endfunction

    function automatic sfcs_pkg::in_item_t noise_item();
        sfcs_pkg::in_item_t it;
        it = random_fields();
        // keep an accidental read short
        if (it.mode == sfcs_pkg::MODE_REQ && it.operation == sfcs_pkg::OP_READ)
            it.length = 16'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic finish_op();
        while (sb.ph != sfcs_pkg::PH_IDLE) push_item(follow_item());
    endtask

    task automatic run_op(sfcs_pkg::op_t op, logic [23:0] a, logic [15:0] len, logic pk,
                          logic [2:0] si);
        sfcs_pkg::in_item_t it;
        it = random_fields();
        it.mode = sfcs_pkg::MODE_REQ;
        it.operation = op;
        it.address = a;
        it.length = len;
        it.pack_words = pk;
        it.status_index = si;
        push_item(it);
        finish_op();
    endtask

    task automatic drain();
        pause(1);
        while (sb.actions_due.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_cfg(sfcs_pkg::cfg_idx_t idx, logic [7:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        if (idx == sfcs_pkg::CFG_ALIGN_MASK) sb.align_mask = v;
        else sb.page_limit = v[6:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_run(int n_items);
        int burst;
        int issued;
        issued = 0;
        while (issued < n_items) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                if ($urandom_range(0, 11) == 0) push_item(noise_item());
                else if (sb.ph == sfcs_pkg::PH_IDLE) push_item(random_request());
                else push_item(follow_item());
                issued++;
            end
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
        end
        finish_op();
    endtask

    initial begin
        sfcs_pkg::in_item_t it;
        sb = new();
        sb.clear();
        n_errors = 0;
        n_sent = 0;
        n_requests = 0;
        hold_req = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = sfcs_pkg::CFG_ALIGN_MASK;
        cfg_wdata = '0;
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed: every operation and the odd cases
        run_op(sfcs_pkg::OP_READ, 24'hFFFFFF, 16'd0, 1'b0, 3'd0);
        run_op(sfcs_pkg::OP_READ, 24'h000000, 16'd3, 1'b0, 3'd7);
        run_op(sfcs_pkg::OP_READ, 24'h123456, 16'd2, 1'b1, 3'd0);
        run_op(sfcs_pkg::OP_PROG, 24'h000000, 16'd2, 1'b0, 3'd0);
        run_op(sfcs_pkg::OP_PROG, 24'hFFFFC0, 16'd0, 1'b0, 3'd0);
        run_op(sfcs_pkg::OP_PROG, 24'h000000, 16'hFFFF, 1'b0, 3'd0);
        run_op(sfcs_pkg::OP_PROG, 24'h000001, 16'd1, 1'b0, 3'd0);
        run_op(sfcs_pkg::OP_SERASE, 24'hABCDEF, 16'd0, 1'b0, 3'd0);
        run_op(sfcs_pkg::OP_CERASE, 24'h000000, 16'd0, 1'b0, 3'd0);
        for (int s = 0; s < 8; s++) run_op(sfcs_pkg::OP_STATUS, '0, '0, 1'b0, 3'(s));
        run_op(sfcs_pkg::OP_ID, 24'h555555, 16'd0, 1'b0, 3'd0);
        run_op(sfcs_pkg::OP_WREN, '0, '0, 1'b0, 3'd0);
        run_op(sfcs_pkg::OP_RESET, '0, '0, 1'b0, 3'd0);
        run_op(sfcs_pkg::OP_QUAD, '0, '0, 1'b0, 3'd0);
        run_op(sfcs_pkg::op_t'(4'd15), '0, '0, 1'b0, 3'd0);
        it = random_fields();
        it.mode = sfcs_pkg::MODE_NONE;
        push_item(it);
        it.mode = sfcs_pkg::MODE_DATA;
        push_item(it);
        it.mode = sfcs_pkg::MODE_RX;
        push_item(it);
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_cfg(sfcs_pkg::CFG_ALIGN_MASK, 8'h00);
                    write_cfg(sfcs_pkg::CFG_PAGE_LIMIT, 8'd1);
                end
                1: begin
                    write_cfg(sfcs_pkg::CFG_ALIGN_MASK, 8'hFF);
                    write_cfg(sfcs_pkg::CFG_PAGE_LIMIT, 8'd64);
                end
                default: begin
                    write_cfg(sfcs_pkg::CFG_ALIGN_MASK, 8'($urandom));
                    write_cfg(sfcs_pkg::CFG_PAGE_LIMIT, 8'($urandom_range(1, 64)));
                end
            endcase
            if (p == 1) hold_req = 1'b1;
            random_run(25);
            drain();
            random_run(25);
            drain();
        end

        $display("ran %0d operations, %0d items with results, %0d results checked",
                 n_requests, n_sent, sb.n_results);
        $display("covered all operations, error cases and four configurations");
        if (n_errors == 0 && sb.actions_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/sfcs_pkg.sv
rtl/core/sfcs_engine.sv
rtl/core/sfcs_out_queue.sv
rtl/core/spi_nor_flash_command_sequencer_unit.sv
test/tb_spi_nor_flash_command_sequencer_unit.sv
